FILE: hw/rtl/ps2f_pkg.sv
`timescale 1ns / 1ps
package ps2f_pkg;

  typedef enum logic [1:0] {
    FMT_PCM   = 2'd0,
    FMT_FLOAT = 2'd1,
    FMT_UNSUP = 2'd2,
    FMT_RSVD  = 2'd3
  } fmt_e;

  localparam logic [0:0] REG_SAMPLE_BITS   = 1'b0;
  localparam logic [0:0] REG_SAMPLE_FORMAT = 1'b1;

  localparam logic [6:0] BITS_8  = 7'd8;
  localparam logic [6:0] BITS_16 = 7'd16;
  localparam logic [6:0] BITS_24 = 7'd24;
  localparam logic [6:0] BITS_32 = 7'd32;
  localparam logic [6:0] BITS_RESET = 7'd16;

  // decoded sample, handed from the input stage to the float encoder
  typedef struct packed {
    logic        pass;   // float passthrough
    logic        zero;   // force +0.0
    logic        neg;
    logic [31:0] mag;    // magnitude, up to 2^31
    logic [7:0]  bias;   // 127 - scale
    logic [31:0] raw;
  } dec_t;

endpackage

FILE: hw/rtl/ps2f_encode.sv
`timescale 1ns / 1ps
// magnitude to float32 with round to nearest even, or raw float passthrough or forced +0.0
module ps2f_encode (
  input  ps2f_pkg::dec_t dec_i,
  output logic [31:0]    float_bits_o
);

  logic [4:0]  msb;
  logic [31:0] norm;     // mag shifted so leading one is at bit 31
  logic [24:0] keep;
  logic        rnd;
  logic        sticky;
  logic [7:0]  expo;
  logic [22:0] frac;

  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (dec_i.mag[i]) msb = 5'(i);
    end
    norm   = dec_i.mag << (5'd31 - msb);
    rnd    = norm[7];
    sticky = |norm[6:0];
    keep   = {1'b0, norm[31:8]} +
             25'((rnd && (sticky || norm[8])) ? 1 : 0);
    if (keep[24]) begin
      frac = keep[23:1];
      expo = 8'(msb) + 8'd1 + dec_i.bias;
    end else begin
      frac = keep[22:0];
      expo = 8'(msb) + dec_i.bias;
    end
    if (dec_i.pass) begin
      float_bits_o = dec_i.raw;
    end else if (dec_i.zero || dec_i.mag == 32'd0) begin
      float_bits_o = 32'd0;
    end else begin
      float_bits_o = {dec_i.neg, expo, frac};
    end
  end

endmodule

FILE: hw/rtl/pcm_sample_to_float.sv
`timescale 1ns / 1ps
// start passes through the input register and the result register to the done strobe
// throughput: one transaction per cycle, busy is always low
// reset: sample_bits 16, sample_format integer pcm, no result pending
// input register then decode and float encode into the result register
// the receiver cannot stall, done_o marks each result for one cycle and the result holds until the next
module pcm_sample_to_float (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] raw_sample_i,
  input  logic        silent_i,
  input  logic        last_in_i,
  output logic        done_o,
  output logic [31:0] float_bits_o,
  output logic        format_error_o,
  output logic        last_out_o
);

  logic [6:0]  sample_bits_q;
  logic [1:0]  sample_format_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_bits_q   <= ps2f_pkg::BITS_RESET;
      sample_format_q <= ps2f_pkg::FMT_PCM;
    end else if (cfg_wr && paddr[1:0] == 2'd0) begin
      case (paddr[2])
        ps2f_pkg::REG_SAMPLE_BITS:   sample_bits_q   <= pwdata[6:0];
        ps2f_pkg::REG_SAMPLE_FORMAT: sample_format_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      ps2f_pkg::REG_SAMPLE_BITS:   prdata = {25'd0, sample_bits_q};
      ps2f_pkg::REG_SAMPLE_FORMAT: prdata = {30'd0, sample_format_q};
      default:                     prdata = 32'd0;
    endcase
  end

  // input register
  logic        vld_q;
  logic [31:0] raw_q;
  logic        silent_q;
  logic        last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= start;
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      raw_q    <= raw_sample_i;
      silent_q <= silent_i;
      last_q   <= last_in_i;
    end
  end

  // decode per sample width
  ps2f_pkg::dec_t dec;
  logic           err;
  logic [31:0]    sx;

  always_comb begin
    err = (sample_format_q == ps2f_pkg::FMT_UNSUP) ||
          (sample_format_q == ps2f_pkg::FMT_RSVD) || (sample_bits_q < ps2f_pkg::BITS_8);
    dec      = '0;
    dec.raw  = raw_q;
    dec.zero = err || silent_q;
    sx       = 32'd0;
    if (sample_format_q == ps2f_pkg::FMT_FLOAT && sample_bits_q == ps2f_pkg::BITS_32) begin
      dec.pass = 1'b1;
    end else begin
      case (sample_bits_q)
        ps2f_pkg::BITS_8: begin
          sx       = {24'd0, raw_q[7:0]} - 32'd128;
          dec.bias = 8'd120;
        end
        ps2f_pkg::BITS_16: begin
          sx       = {{16{raw_q[15]}}, raw_q[15:0]};
          dec.bias = 8'd112;
        end
        ps2f_pkg::BITS_24: begin
          sx       = {{8{raw_q[23]}}, raw_q[23:0]};
          dec.bias = 8'd104;
        end
        ps2f_pkg::BITS_32: begin
          sx       = raw_q;
          dec.bias = 8'd96;
        end
        default: sx = 32'd0;
      endcase
      dec.neg = sx[31];
      dec.mag = sx[31] ? (32'd0 - sx) : sx;
    end
    if (dec.zero) dec.pass = 1'b0;
  end

  logic [31:0] enc_bits;

  ps2f_encode u_encode (
    .dec_i        (dec),
    .float_bits_o (enc_bits)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      float_bits_o   <= enc_bits;
      format_error_o <= err;
      last_out_o     <= last_q;
    end
  end

endmodule
